@@ sv/fixed_block_free_list_allocator_assert.svh @@
// assertion macros for the fixed block free list allocator
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication, disabled in reset
`define FBFL_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fbfl check failed");
// next-cycle implication, disabled in reset
`define FBFL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fbfl check failed");
`else
`define FBFL_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define FBFL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ sv/fbfl_pkg.sv @@
// types, codes and constants shared by the allocator files
package fbfl_pkg;

  localparam int MAX_BLOCKS     = 1024;
  localparam int BYTES_PER_WORD = 8;
  localparam int IDX_W          = $clog2(MAX_BLOCKS);
  localparam int CNT_W          = 11;
  localparam int BYTES_W        = 13;
  localparam int RSIZE_W        = BYTES_W + 1;
  localparam int OFF_W          = 22;
  localparam int CMD_W          = 2;
  localparam int STATUS_W       = 2;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = BYTES_W;

  localparam logic [CNT_W-1:0]   BLOCK_COUNT_RESET = CNT_W'(1024);
  localparam logic [BYTES_W-1:0] BLOCK_BYTES_RESET = BYTES_W'(64);
  localparam logic [CNT_W-1:0]   CNT_MAX           = {CNT_W{1'b1}};

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES = 1'b1;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [IDX_W-1:0] block_index;
  } alloc_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    given_index;
    logic [OFF_W-1:0]    given_offset;
    logic [CNT_W-1:0]    free_count;
  } alloc_rsp_t;

endpackage

@@ sv/fbfl_ram.sv @@
// generic simple dual-port ram with registered read
module fbfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/fixed_block_free_list_allocator.sv @@
// top level of the fixed block free list allocator
//
//   port group   dir   handshake            payload
//   in_*         in    in_valid/in_ready    alloc_req_t  (command, block_index)
//   out_*        out   out_valid/out_ready  alloc_rsp_t  (status, index, offset, count)
//   cfg_*        in    cfg_write only       cfg_index selects register, cfg_data
//
// one item at a time: accept, execute, multiply, then load the output register,
// so no new item is taken while one is in flight
// the steps come from the registered read of the link memory and the
// registered offset multiply that follows it
// a waiting result holds the block in its output step; input is accepted again
// as soon as the result has moved into the output register
// rst is synchronous and needs no memory clearing pass
`include "fixed_block_free_list_allocator_assert.svh"

module fixed_block_free_list_allocator
  import fbfl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  alloc_req_t            in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output alloc_rsp_t            out_data,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_MUL,
    S_OUT
  } state_t;

  state_t state;

  // configuration registers
  logic [CNT_W-1:0]   block_count;
  logic [BYTES_W-1:0] block_bytes;

  // free list state
  logic [IDX_W-1:0] head_index;
  logic [CNT_W-1:0] fresh_mark;
  logic [CNT_W-1:0] freed_stack_size;
  logic [CNT_W-1:0] free_total;

  // captured item and intermediate results
  logic [CMD_W-1:0]    cmd_q;
  logic [IDX_W-1:0]    idx_q;
  logic [IDX_W-1:0]    given_q;
  logic [STATUS_W-1:0] status_q;
  logic [OFF_W-1:0]    prod_q;

  // derived values
  logic [CNT_W-1:0]         eff_count;
  logic [RSIZE_W-1:0]       rsize;
  logic [IDX_W+RSIZE_W-1:0] prod_full;
  logic                     in_beat;
  logic                     free_ok;
  logic                     link_wr;
  logic [IDX_W-1:0]         link_rd_data;

  assign in_ready  = (state == S_IDLE);
  assign in_beat   = in_valid && in_ready;

  // pool size is capped at the link memory depth
  assign eff_count = (block_count > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : block_count;

  // block size rounded up to whole words
  assign rsize = (RSIZE_W'(block_bytes) + RSIZE_W'(BYTES_PER_WORD - 1))
               & ~RSIZE_W'(BYTES_PER_WORD - 1);

  assign prod_full = given_q * rsize;

  assign free_ok = (CNT_W'(idx_q) < eff_count);
  // a good free links the old head under the freed block
  assign link_wr = (state == S_EXEC) && (cmd_q == CMD_FREE) && free_ok;

  // link memory, read at the head on every accepted item
  fbfl_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_BLOCKS)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (link_wr),
    .wr_addr (idx_q),
    .wr_data (head_index),
    .rd_en   (in_beat),
    .rd_addr (head_index),
    .rd_data (link_rd_data)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= BLOCK_COUNT_RESET;
      block_bytes <= BLOCK_BYTES_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BLOCK_COUNT: block_count <= cfg_data[CNT_W-1:0];
        REG_BLOCK_BYTES: block_bytes <= cfg_data[BYTES_W-1:0];
        default:         ;
      endcase
    end
  end

  // sequencer, free list state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      head_index       <= '0;
      fresh_mark       <= '0;
      freed_stack_size <= '0;
      free_total       <= BLOCK_COUNT_RESET;
    end else begin
      // output beat taken; the output step reloads it itself
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_beat) begin
            cmd_q <= in_data.command;
            idx_q <= in_data.block_index;
            state <= S_EXEC;
          end
        end

        S_EXEC: begin
          given_q  <= '0;
          status_q <= ST_OK;
          unique case (cmd_q)
            CMD_INIT: begin
              fresh_mark       <= '0;
              freed_stack_size <= '0;
              head_index       <= '0;
              free_total       <= eff_count;
            end
            CMD_ALLOC: begin
              priority if (freed_stack_size != '0) begin
                // pop the freed stack, link data is the new head
                given_q          <= head_index;
                head_index       <= link_rd_data;
                freed_stack_size <= freed_stack_size - CNT_W'(1);
                if (free_total != '0) begin
                  free_total <= free_total - CNT_W'(1);
                end
              end else if (fresh_mark < eff_count) begin
                // hand out the lowest never-used block
                given_q    <= fresh_mark[IDX_W-1:0];
                fresh_mark <= fresh_mark + CNT_W'(1);
                if (free_total != '0) begin
                  free_total <= free_total - CNT_W'(1);
                end
              end else begin
                status_q <= ST_EMPTY;
              end
            end
            CMD_FREE: begin
              if (free_ok) begin
                head_index <= idx_q;
                if (freed_stack_size != CNT_MAX) begin
                  freed_stack_size <= freed_stack_size + CNT_W'(1);
                end
                if (free_total != CNT_MAX) begin
                  free_total <= free_total + CNT_W'(1);
                end
              end else begin
                status_q <= ST_BAD_INDEX;
              end
            end
            default: ;
          endcase
          state <= S_MUL;
        end

        S_MUL: begin
          // offset wraps to its field width; zero index gives zero offset
          prod_q <= prod_full[OFF_W-1:0];
          state  <= S_OUT;
        end

        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid             <= 1'b1;
            out_data.status       <= status_q;
            out_data.given_index  <= given_q;
            out_data.given_offset <= prod_q;
            out_data.free_count   <= free_total;
            state                 <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  `FBFL_ASSERT_NEXT(a_accept_exec, clk, rst, in_beat, state == S_EXEC)
  `FBFL_ASSERT_IMPLY(a_out_from_out_state, clk, rst, $rose(out_valid), $past(state) == S_OUT)
  `FBFL_ASSERT_IMPLY(a_stack_within_total, clk, rst, 1'b1, freed_stack_size <= free_total)
  `FBFL_ASSERT_IMPLY(a_fresh_bounded, clk, rst, 1'b1, fresh_mark <= CNT_W'(MAX_BLOCKS))

endmodule

@@ tb/tb.sv @@
// self-checking testbench for the fixed block free list allocator
module tb
  import fbfl_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // command code 3 has no name in the package; the block treats it as a no-op
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // cycles to let pass once the last result is in
  localparam int SETTLE_CYCLES = 8;
  // length of the receiver hold-off in the backpressure test
  localparam int HOLD_CYCLES = 300;
  // beats sent in each random phase
  localparam int PHASE_BEATS = 170;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  alloc_req_t in_data;
  logic       out_valid;
  logic       out_ready;
  alloc_rsp_t out_data;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  fixed_block_free_list_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shared run state
  bit         failed = 1'b0;
  int         idle_pct = 25;     // chance in percent that a side idles in a cycle
  bit         hold_req = 1'b0;   // asks the receiver for one long hold-off
  alloc_rsp_t last_predicted;    // prediction for the most recently accepted beat
  alloc_rsp_t pending_rsp[$];    // predicted results still to come out

  // allocator state as the testbench tracks it
  logic [IDX_W-1:0]   link_mem [MAX_BLOCKS];  // next link of each freed block
  logic [IDX_W-1:0]   top_idx     = '0;       // top of the freed stack
  logic [CNT_W-1:0]   next_fresh  = '0;       // lowest block never handed out since init
  logic [CNT_W-1:0]   stack_depth = '0;       // entries on the freed stack
  logic [CNT_W-1:0]   free_blocks = BLOCK_COUNT_RESET;
  logic [CNT_W-1:0]   cfg_count   = BLOCK_COUNT_RESET;
  logic [BYTES_W-1:0] cfg_bytes   = BLOCK_BYTES_RESET;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #10ms;
    $display("fixed_block_free_list_allocator: mismatch");
    $finish;
  end

  // -------------------------------------------------------------------------
  // prediction: apply one command to the tracked pool and build its result
  // -------------------------------------------------------------------------
  task automatic apply_command(input alloc_req_t req, output alloc_rsp_t rsp);
    int unsigned n;
    int unsigned rsize;
    int unsigned given;
    // counts above the pool size act as the pool size
    n = (cfg_count < MAX_BLOCKS) ? cfg_count : MAX_BLOCKS;
    // block size rounded up to whole words
    rsize = ((int'(cfg_bytes) + BYTES_PER_WORD - 1) / BYTES_PER_WORD) * BYTES_PER_WORD;
    given = 0;
    rsp = '0;
    case (req.command)
      CMD_INIT: begin
        next_fresh  = '0;
        stack_depth = '0;
        top_idx     = '0;
        free_blocks = CNT_W'(n);
      end
      CMD_ALLOC: begin
        // freed blocks go out first, newest first; then never-used ones in order
        if (stack_depth != 0) begin
          given = top_idx;
          top_idx = link_mem[top_idx];
          stack_depth = stack_depth - 1'b1;
        end else if (next_fresh < n) begin
          given = next_fresh;
          next_fresh = next_fresh + 1'b1;
        end else begin
          rsp.status = ST_EMPTY;
        end
        if (rsp.status == ST_OK) begin
          // free count floors at zero after a shrink without init
          if (free_blocks != 0) free_blocks = free_blocks - 1'b1;
          rsp.given_index  = IDX_W'(given);
          // offset wraps at its field width
          rsp.given_offset = OFF_W'(given * rsize);
        end
      end
      CMD_FREE: begin
        if (req.block_index >= n) begin
          rsp.status = ST_BAD_INDEX;
        end else begin
          // double frees go through; both counts saturate
          link_mem[req.block_index] = top_idx;
          top_idx = req.block_index;
          if (stack_depth != CNT_MAX) stack_depth = stack_depth + 1'b1;
          if (free_blocks != CNT_MAX) free_blocks = free_blocks + 1'b1;
        end
      end
      default: ;
    endcase
    rsp.free_count = free_blocks;
  endtask

  // -------------------------------------------------------------------------
  // input side: one beat, with a random gap in front of it
  // -------------------------------------------------------------------------
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx);
    alloc_req_t req;
    req.command     = cmd;
    req.block_index = idx;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    // valid stays up from a previous beat if there was no gap
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_command(req, last_predicted);
    pending_rsp.push_back(last_predicted);
  endtask

  // stop sending and let every result drain out before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input int unsigned value);
    settle();
    cfg_write <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_write <= 1'b0;
    if (sel == REG_BLOCK_COUNT) cfg_count = CNT_W'(value);
    else cfg_bytes = BYTES_W'(value);
  endtask

  // -------------------------------------------------------------------------
  // output side: random ready, plus one long hold-off on request
  // -------------------------------------------------------------------------
  initial begin : receiver
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= idle_pct);
      end
    end
  end

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s differs, expected %0d, got %0d", $time, name, want, got);
      failed = 1'b1;
    end
  endtask

  // every result beat is matched against the oldest prediction
  always @(posedge clk) begin : rsp_check
    alloc_rsp_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: result with nothing pending, got %p", $time, out_data);
        failed = 1'b1;
      end else begin
        want = pending_rsp.pop_front();
        compare_field("status", want.status, out_data.status);
        compare_field("given_index", want.given_index, out_data.given_index);
        compare_field("given_offset", want.given_offset, out_data.given_offset);
        compare_field("free_count", want.free_count, out_data.free_count);
      end
    end
  end

  // -------------------------------------------------------------------------
  // tests
  // -------------------------------------------------------------------------

  // reset values of the registers and the pool, no init sent first
  task automatic test_reset_defaults();
    send_cmd(CMD_ALLOC, 10'h3FF);
    send_cmd(CMD_ALLOC, 10'h000);
    send_cmd(CMD_FREE, 10'd1023);
    send_cmd(CMD_ALLOC, 10'h2AA);
    send_cmd(CMD_UNUSED, 10'h3FF);
  endtask

  // single-block pool: empty pool, bad index, double free
  task automatic test_tiny_pool();
    write_reg(REG_BLOCK_COUNT, 1);
    write_reg(REG_BLOCK_BYTES, 1);
    send_cmd(CMD_INIT, 10'h3FF);
    send_cmd(CMD_ALLOC, 10'h155);
    send_cmd(CMD_ALLOC, 10'h000);
    send_cmd(CMD_FREE, 10'd1);
    send_cmd(CMD_FREE, 10'd1023);
    send_cmd(CMD_FREE, 10'd0);
    send_cmd(CMD_FREE, 10'd0);
    send_cmd(CMD_ALLOC, 10'h000);
    send_cmd(CMD_ALLOC, 10'h000);
    send_cmd(CMD_ALLOC, 10'h000);
  endtask

  // offset at the top index for the size extremes, zero size and wrap
  task automatic test_offsets();
    write_reg(REG_BLOCK_COUNT, 2047);   // larger than the pool, acts as 1024
    write_reg(REG_BLOCK_BYTES, 4096);
    send_cmd(CMD_INIT, 10'h000);
    send_cmd(CMD_FREE, 10'd1023);
    send_cmd(CMD_ALLOC, 10'h000);
    write_reg(REG_BLOCK_BYTES, 0);
    send_cmd(CMD_FREE, 10'd1023);
    send_cmd(CMD_ALLOC, 10'h000);
    write_reg(REG_BLOCK_BYTES, 8191);  // rounds to 8192, top offsets wrap
    send_cmd(CMD_FREE, 10'd1023);
    send_cmd(CMD_ALLOC, 10'h000);
    write_reg(REG_BLOCK_BYTES, 9);
    send_cmd(CMD_FREE, 10'd5);
    send_cmd(CMD_ALLOC, 10'h000);
  endtask

  // count register changes without init: free count floors at zero
  task automatic test_count_change();
    write_reg(REG_BLOCK_COUNT, 4);
    send_cmd(CMD_INIT, 10'h000);
    write_reg(REG_BLOCK_COUNT, 1024);
    repeat (6) send_cmd(CMD_ALLOC, 10'h000);
    write_reg(REG_BLOCK_COUNT, 2);
    send_cmd(CMD_FREE, 10'd3);
    send_cmd(CMD_ALLOC, 10'h000);
  endtask

  // repeated frees of one block push the free count into saturation, then drain
  task automatic test_saturation();
    write_reg(REG_BLOCK_COUNT, 1024);
    write_reg(REG_BLOCK_BYTES, 64);
    send_cmd(CMD_INIT, 10'h000);
    repeat (1030) send_cmd(CMD_FREE, 10'd7);
    repeat (40) send_cmd(CMD_ALLOC, 10'h000);
  endtask

  // receiver stops for a long while; the sender keeps offering and stalls
  task automatic test_backpressure();
    idle_pct = 0;
    hold_req = 1'b1;
    for (int i = 0; i < 24; i++) begin
      if (i % 2 == 0) send_cmd(CMD_ALLOC, 10'h000);
      else send_cmd(CMD_FREE, IDX_W'($urandom_range(0, 15)));
    end
    settle();
    idle_pct = 25;
  endtask

  // mostly well-formed alloc/free traffic over several register settings
  task automatic test_random_traffic();
    logic [IDX_W-1:0] held[$];
    int unsigned pick;
    int unsigned pos;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_BLOCK_COUNT, 1);
          write_reg(REG_BLOCK_BYTES, 8191);
        end
        1: begin
          write_reg(REG_BLOCK_COUNT, 1024);
          write_reg(REG_BLOCK_BYTES, 4096);
        end
        2: begin
          write_reg(REG_BLOCK_COUNT, $urandom_range(2, 16));
          write_reg(REG_BLOCK_BYTES, $urandom_range(1, 4096));
        end
        3: begin
          write_reg(REG_BLOCK_COUNT, 2047);
          write_reg(REG_BLOCK_BYTES, 1);
        end
        default: begin
          write_reg(REG_BLOCK_COUNT, $urandom_range(1, 1024));
          write_reg(REG_BLOCK_BYTES, $urandom_range(1, 8191));
        end
      endcase
      // one phase runs with no idling on either side
      idle_pct = (ph == 1) ? 0 : 25;
      held.delete();
      send_cmd(CMD_INIT, IDX_W'($urandom_range(0, 1023)));
      for (int i = 0; i < PHASE_BEATS; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
          send_cmd(CMD_INIT, IDX_W'($urandom_range(0, 1023)));
          held.delete();
        end else if (pick < 4) begin
          send_cmd(CMD_UNUSED, IDX_W'($urandom_range(0, 1023)));
        end else if (pick < 50) begin
          send_cmd(CMD_ALLOC, IDX_W'($urandom_range(0, 1023)));
          if (last_predicted.status == ST_OK) held.push_back(last_predicted.given_index);
        end else if (held.size() != 0 && $urandom_range(0, 9) < 8) begin
          // return a block that is actually out
          pos = $urandom_range(0, held.size() - 1);
          send_cmd(CMD_FREE, held[pos]);
          held.delete(pos);
        end else begin
          // noise: bad indexes and double frees
          send_cmd(CMD_FREE, IDX_W'($urandom_range(0, 1023)));
        end
      end
    end
    idle_pct = 25;
  endtask

  // -------------------------------------------------------------------------
  // main sequence
  // -------------------------------------------------------------------------
  initial begin : stimulus
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_tiny_pool();
    test_offsets();
    test_count_change();
    test_backpressure();
    test_saturation();
    test_random_traffic();

    settle();
    if (failed) begin
      $display("fixed_block_free_list_allocator: mismatch");
    end else begin
      $display("fixed_block_free_list_allocator: match");
    end
    $finish;
  end

endmodule
